[hw/rtl/dlr_pkg.sv]
package dlr_pkg;

    // Coordinate width and the widths that follow from it
    localparam int COORD_BITS  = 10;
    localparam int SW          = COORD_BITS + 1;        // signed offset / slope term
    localparam int PROD_W      = 2 * SW;                // signed product
    localparam int MAG_W       = PROD_W;                // magnitude of the rounding numerator
    localparam int QW          = COORD_BITS + 1;        // quotient bits, divider steps
    localparam int CNT_W       = $clog2(QW);

    // Word queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef enum logic
    {
        STEP_X = 1'b0,
        STEP_Y = 1'b1
    } step_mode_t;

    // One word of work handed from the front to the back
    typedef struct packed
    {
        logic                          interp;  // needs the interpolation unit
        step_mode_t                    mode;
        logic                          valid;
        logic [COORD_BITS-1:0]         x;
        logic [COORD_BITS-1:0]         y;
        logic                          last;
        logic [COORD_BITS-1:0]         base;
        logic signed [SW-1:0]          diff;
        logic signed [SW-1:0]          num;
        logic [COORD_BITS-1:0]         dabs;
    } job_t;

endpackage

[hw/rtl/direct_line_rasterizer_unit.sv]
// Direct slope-intercept line rasterizer.
// Input channel (push/full): a word with func = start carries both endpoints
// and yields the first endpoint; a word with func = tick yields the next pixel
// of the line, the second endpoint last with last_pixel set, and pixel_valid
// low once no line is in progress. A start word drops any line in progress.
// Result channel (empty/pop): the oldest result word sits on the pixel ports
// while empty is low and leaves on pop.
// The front takes one input word per cycle into a four-word queue while full
// is low. Start words, endpoint words and idle ticks pass through the queue
// and are registered into the result word. An interior pixel passes through a
// take cycle, a multiply, a load cycle, an 11-step restoring divide
// (COORD_BITS + 1 steps) and a result cycle; the back takes no new word until
// that pixel's result is written.
// When the receiver stalls the result word holds, the back stops after its
// current pixel, the queue fills and full rises.
// Reset clears the line state, the queue and the result slot: empty is high
// and no line is in progress.
module direct_line_rasterizer_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             func,
    input  logic [dlr_pkg::COORD_BITS-1:0]   start_x,
    input  logic [dlr_pkg::COORD_BITS-1:0]   start_y,
    input  logic [dlr_pkg::COORD_BITS-1:0]   end_x,
    input  logic [dlr_pkg::COORD_BITS-1:0]   end_y,
    output logic                             empty,
    input  logic                             pop,
    output logic                             pixel_valid,
    output logic [dlr_pkg::COORD_BITS-1:0]   pixel_x,
    output logic [dlr_pkg::COORD_BITS-1:0]   pixel_y,
    output logic                             last_pixel
);
    import dlr_pkg::*;

    logic  accept;
    logic  q_empty, job_take;
    job_t  front_job, back_job;

    assign accept = push && !full;

    dlr_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .func    (func),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .job     (front_job)
    );

    dlr_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_job  (front_job),
        .rd_en   (job_take),
        .rd_job  (back_job),
        .q_full  (full),
        .q_empty (q_empty)
    );

    dlr_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (back_job),
        .job_avail   (!q_empty),
        .job_take    (job_take),
        .empty       (empty),
        .pop         (pop),
        .pixel_valid (pixel_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .last_pixel  (last_pixel)
    );

endmodule

[hw/rtl/dlr_front.sv]
module dlr_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             func,
    input  logic [dlr_pkg::COORD_BITS-1:0]   start_x,
    input  logic [dlr_pkg::COORD_BITS-1:0]   start_y,
    input  logic [dlr_pkg::COORD_BITS-1:0]   end_x,
    input  logic [dlr_pkg::COORD_BITS-1:0]   end_y,
    output dlr_pkg::job_t                    job
);
    import dlr_pkg::*;

    logic                    active_reg, active_next;
    step_mode_t              mode_reg, mode_next;
    logic [SW-1:0]           pos_reg, pos_next;
    logic [COORD_BITS-1:0]   limit_reg, limit_next;
    logic [COORD_BITS-1:0]   x2_reg, x2_next;
    logic [COORD_BITS-1:0]   y2_reg, y2_next;
    logic [COORD_BITS-1:0]   base_reg, base_next;
    logic [COORD_BITS-1:0]   t0_reg, t0_next;
    logic signed [SW-1:0]    num_reg, num_next;
    logic [COORD_BITS-1:0]   dabs_reg, dabs_next;

    logic signed [SW-1:0]    dx, dy, ndx, ndy, num_raw, den_raw;
    logic [SW-1:0]           adx_w, ady_w, aden_w;
    logic [COORD_BITS-1:0]   adx, ady, lo, hi;
    step_mode_t              mode_new;

    // Classify the line from its endpoints
    always_comb
    begin
        dx     = $signed({1'b0, end_x} - {1'b0, start_x});
        dy     = $signed({1'b0, end_y} - {1'b0, start_y});
        ndx    = -dx;
        ndy    = -dy;
        adx_w  = dx[SW-1] ? ndx : dx;
        ady_w  = dy[SW-1] ? ndy : dy;
        adx    = adx_w[COORD_BITS-1:0];
        ady    = ady_w[COORD_BITS-1:0];
        if ((dx != '0) && (ady <= adx))
        begin
            mode_new = STEP_X;
            lo       = (start_x < end_x) ? start_x : end_x;
            hi       = (start_x < end_x) ? end_x : start_x;
            num_raw  = dy;
            den_raw  = dx;
        end
        else
        begin
            mode_new = STEP_Y;
            lo       = (start_y < end_y) ? start_y : end_y;
            hi       = (start_y < end_y) ? end_y : start_y;
            num_raw  = dx;
            den_raw  = dy;
        end
        aden_w = den_raw[SW-1] ? -den_raw : den_raw;
    end

    // Advance the line state and build the word for the back
    always_comb
    begin
        active_next = active_reg;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        limit_next  = limit_reg;
        x2_next     = x2_reg;
        y2_next     = y2_reg;
        base_next   = base_reg;
        t0_next     = t0_reg;
        num_next    = num_reg;
        dabs_next   = dabs_reg;

        job.interp  = 1'b0;
        job.mode    = mode_reg;
        job.valid   = 1'b0;
        job.x       = '0;
        job.y       = '0;
        job.last    = 1'b0;
        job.base    = base_reg;
        job.diff    = $signed({1'b0, pos_reg[COORD_BITS-1:0]} - {1'b0, t0_reg});
        job.num     = num_reg;
        job.dabs    = dabs_reg;

        if (func == FUNC_START)
        begin
            active_next = 1'b1;
            mode_next   = mode_new;
            pos_next    = {1'b0, lo} + SW'(1);
            limit_next  = hi;
            x2_next     = end_x;
            y2_next     = end_y;
            base_next   = (mode_new == STEP_X) ? start_y : start_x;
            t0_next     = (mode_new == STEP_X) ? start_x : start_y;
            num_next    = den_raw[SW-1] ? -num_raw : num_raw;
            dabs_next   = aden_w[COORD_BITS-1:0];
            job.valid   = 1'b1;
            job.x       = start_x;
            job.y       = start_y;
        end
        else if (active_reg)
        begin
            if (pos_reg < {1'b0, limit_reg})
            begin
                job.interp = 1'b1;
                job.valid  = 1'b1;
                job.x      = pos_reg[COORD_BITS-1:0];
                job.y      = pos_reg[COORD_BITS-1:0];
                pos_next   = pos_reg + SW'(1);
            end
            else
            begin
                job.valid   = 1'b1;
                job.x       = x2_reg;
                job.y       = y2_reg;
                job.last    = 1'b1;
                active_next = 1'b0;
            end
        end
    end

    // Hold the line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            mode_reg   <= STEP_X;
            pos_reg    <= '0;
            limit_reg  <= '0;
            x2_reg     <= '0;
            y2_reg     <= '0;
            base_reg   <= '0;
            t0_reg     <= '0;
            num_reg    <= '0;
            dabs_reg   <= '0;
        end
        else if (accept)
        begin
            active_reg <= active_next;
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            limit_reg  <= limit_next;
            x2_reg     <= x2_next;
            y2_reg     <= y2_next;
            base_reg   <= base_next;
            t0_reg     <= t0_next;
            num_reg    <= num_next;
            dabs_reg   <= dabs_next;
        end
    end

endmodule

[hw/rtl/dlr_queue.sv]
module dlr_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  dlr_pkg::job_t   wr_job,
    input  logic            rd_en,
    output dlr_pkg::job_t   rd_job,
    output logic            q_full,
    output logic            q_empty
);
    import dlr_pkg::*;

    job_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign q_full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

[hw/rtl/dlr_back.sv]
module dlr_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  dlr_pkg::job_t                    job,
    input  logic                             job_avail,
    output logic                             job_take,
    output logic                             empty,
    input  logic                             pop,
    output logic                             pixel_valid,
    output logic [dlr_pkg::COORD_BITS-1:0]   pixel_x,
    output logic [dlr_pkg::COORD_BITS-1:0]   pixel_y,
    output logic                             last_pixel
);
    import dlr_pkg::*;

    typedef enum logic [4:0]
    {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } back_state_t;

    back_state_t              state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;

    // Operand and datapath registers
    step_mode_t               mode_reg;
    logic [COORD_BITS-1:0]    step_reg;
    logic [COORD_BITS-1:0]    base_reg;
    logic signed [SW-1:0]     diff_reg;
    logic signed [SW-1:0]     num_reg;
    logic [COORD_BITS-1:0]    dabs_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic [QW-1:0]            rem_reg;
    logic [QW-1:0]            dq_reg;

    // Result word register
    logic                     pix_valid_reg;
    logic [COORD_BITS-1:0]    pix_x_reg, pix_y_reg;
    logic                     last_reg;

    logic                     out_free;
    logic                     take_direct, take_interp, write_done;
    logic signed [PROD_W:0]   a_val, a_neg;
    logic [PROD_W:0]          a_mag;
    logic [QW-1:0]            divisor;
    logic [QW:0]              trial;
    logic                     ge;
    logic [QW-1:0]            rem_step;
    logic [COORD_BITS+1:0]    q_ext, q_signed, coord_sum;
    logic [COORD_BITS-1:0]    coord;

    assign out_free    = !out_valid_reg || pop;
    assign take_direct = (state_reg == S_IDLE) && job_avail && !job.interp && out_free;
    assign take_interp = (state_reg == S_IDLE) && job_avail && job.interp;
    assign job_take    = take_direct || take_interp;
    assign write_done  = (state_reg == S_DONE) && out_free;

    // Rounding numerator 2*n + d and its magnitude
    always_comb
    begin
        a_val = $signed({prod_reg, 1'b0})
              + $signed({{(PROD_W + 1 - COORD_BITS){1'b0}}, dabs_reg});
        a_neg = -a_val;
        a_mag = a_val[PROD_W] ? a_neg : a_val;
    end

    // One restoring divider step
    always_comb
    begin
        divisor  = {dabs_reg, 1'b0};
        trial    = {rem_reg, dq_reg[QW-1]};
        ge       = (trial >= {1'b0, divisor});
        rem_step = ge ? QW'(trial - {1'b0, divisor}) : trial[QW-1:0];
    end

    // Signed floor quotient added to the base coordinate
    always_comb
    begin
        q_ext     = {1'b0, dq_reg};
        q_signed  = neg_reg ? ((COORD_BITS + 2)'(0) - q_ext
                               - (COORD_BITS + 2)'(rem_reg != '0))
                            : q_ext;
        coord_sum = {2'b00, base_reg} + q_signed;
        coord     = coord_sum[COORD_BITS-1:0];
    end

    // Sequence the interpolation unit
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take_interp)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_DIV;
                cnt_next   = CNT_W'(QW - 1);
            end
            S_DIV:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (take_direct || write_done)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath: latch operands, multiply, load and run the divider
    always_ff @(posedge clk)
    begin
        if (take_interp)
        begin
            mode_reg <= job.mode;
            step_reg <= (job.mode == STEP_X) ? job.x : job.y;
            base_reg <= job.base;
            diff_reg <= job.diff;
            num_reg  <= job.num;
            dabs_reg <= job.dabs;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= diff_reg * num_reg;
        end
        if (state_reg == S_LOAD)
        begin
            neg_reg <= a_val[PROD_W];
            rem_reg <= a_mag[MAG_W-1:QW];
            dq_reg  <= a_mag[QW-1:0];
        end
        if (state_reg == S_DIV)
        begin
            rem_reg <= rem_step;
            dq_reg  <= {dq_reg[QW-2:0], ge};
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (take_direct)
        begin
            pix_valid_reg <= job.valid;
            pix_x_reg     <= job.x;
            pix_y_reg     <= job.y;
            last_reg      <= job.last;
        end
        else if (write_done)
        begin
            pix_valid_reg <= 1'b1;
            pix_x_reg     <= (mode_reg == STEP_X) ? step_reg : coord;
            pix_y_reg     <= (mode_reg == STEP_X) ? coord : step_reg;
            last_reg      <= 1'b0;
        end
    end

    assign empty       = !out_valid_reg;
    assign pixel_valid = pix_valid_reg;
    assign pixel_x     = pix_x_reg;
    assign pixel_y     = pix_y_reg;
    assign last_pixel  = last_reg;

endmodule
